// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the segment distance block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define SSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("segment distance assertion failed");

// Clocked assertion that also holds through reset.
`define SSD_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("segment distance assertion failed");

`endif

// File: hw/rtl/ssd_pkg.sv
// Shared constants for the segment-to-segment squared distance pipeline.
// No dependencies; imported by the top level and referenced by the port checker.
package ssd_pkg;

    // result width: integer squared distance, fraction bits dropped
    localparam int OUT_W = 50;

    // parallel tolerance register
    localparam int TOL_W = 32;
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd65536;

endpackage

// File: hw/rtl/ssd_delay.sv
// Enable-gated delay line used to carry operands alongside the pipeline.
// No dependencies.
module ssd_delay #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_dly [N];

    // advance the line on every pipeline step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_q = r_dly[N-1];

endmodule

// File: hw/rtl/ssd_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
// No dependencies; used for the determinant terms and the final squares.
module ssd_mul #(
    parameter int AW = 52
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [AW-1:0]   i_a,
    input  logic signed [AW-1:0]   i_b,
    output logic signed [2*AW-1:0] o_p
);

    localparam int H  = AW / 2;
    localparam int HW = AW - H;
    localparam int PW = 2 * AW;

    logic        [H-1:0]    a_lo, b_lo;
    logic signed [HW-1:0]   a_hi, b_hi;
    logic        [2*H-1:0]  r_ll;
    logic signed [H+HW:0]   r_lh, r_hl;
    logic signed [2*HW-1:0] r_hh;
    logic signed [PW-1:0]   n_p;
    logic signed [PW-1:0]   r_p;

    // split operands: low halves unsigned, high halves carry the sign
    assign a_lo = i_a[H-1:0];
    assign b_lo = i_b[H-1:0];
    assign a_hi = i_a[AW-1:H];
    assign b_hi = i_b[AW-1:H];

    // stage one: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= a_lo * b_lo;
            r_lh <= signed'({1'b0, a_lo}) * b_hi;
            r_hl <= a_hi * signed'({1'b0, b_lo});
            r_hh <= a_hi * b_hi;
        end
    end

    // stage two: align and add
    assign n_p = (PW'(r_hh) <<< (2 * H)) + (PW'(r_lh) <<< H) + (PW'(r_hl) <<< H)
               + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// File: hw/rtl/ssd_div.sv
// Pipelined restoring divider giving num/den as an unsigned fraction, one
// quotient bit per stage. No dependencies; used for both line parameters.
module ssd_div #(
    parameter int NW = 105,
    parameter int QB = 24
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [NW-1:0] i_den,
    output logic [QB:0]          o_q
);

    localparam int MW = NW - 1;
    localparam int RW = MW + QB;

    logic          flag, num_gt;
    logic [MW-1:0] n_num, n_den;
    logic [RW-1:0] r_rem [QB+2];
    logic [MW-1:0] r_dd  [QB+2];
    logic [QB:0]   r_qq  [QB+2];
    logic [RW-1:0] den_sh [QB+1];
    logic [RW-1:0] n_rem  [QB+1];
    logic [QB:0]   n_q    [QB+1];
    logic          ge     [QB+1];

    // zero fraction for a zero or negative numerator or a non-positive
    // denominator; clamp the numerator to the denominator
    always_comb begin
        flag   = (i_num == '0) || i_num[NW-1] || i_den[NW-1] || (i_den == '0);
        num_gt = i_num > i_den;
        if (flag) begin
            n_num = '0;
            n_den = MW'(1);
        end else begin
            n_num = num_gt ? i_den[MW-1:0] : i_num[MW-1:0];
            n_den = i_den[MW-1:0];
        end
    end

    // one trial subtraction per stage, quotient bit QB first
    always_comb begin
        for (int j = 0; j <= QB; j++) begin
            den_sh[j] = RW'(r_dd[j]) << (QB - j);
            ge[j]     = den_sh[j] <= r_rem[j];
            n_rem[j]  = ge[j] ? (r_rem[j] - den_sh[j]) : r_rem[j];
            n_q[j]    = r_qq[j] | ((QB+1)'(ge[j]) << (QB - j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {n_num, {QB{1'b0}}};
            r_dd[0]  <= n_den;
            r_qq[0]  <= '0;
            for (int j = 0; j <= QB; j++) begin
                r_rem[j+1] <= n_rem[j];
                r_dd[j+1]  <= r_dd[j];
                r_qq[j+1]  <= n_q[j];
            end
        end
    end

    assign o_q = r_qq[QB+1];

endmodule

// File: hw/rtl/segment_segment_distance_sq.sv
// Squared closest distance between two 3D segments, fully pipelined. One
// segment pair is taken every cycle unless a waiting result is stalled;
// most of the stages are the two fraction dividers, which resolve one
// quotient bit per stage. A stall on the result side while a result is
// waiting freezes the whole pipeline and is passed back on o_stall in the
// same cycle. The parallel tolerance register may be written at any time
// the pipeline holds no item.
// Depends on ssd_pkg, ssd_delay, ssd_mul and ssd_div.
module segment_segment_distance_sq #(
    parameter int COORD_BITS             = 24,
    parameter int QUOTIENT_FRACTION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ssd_pkg::TOL_W-1:0]        i_cfg_wdata,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [COORD_BITS-1:0]     i_first_start_x,
    input  logic signed [COORD_BITS-1:0]     i_first_start_y,
    input  logic signed [COORD_BITS-1:0]     i_first_start_z,
    input  logic signed [COORD_BITS-1:0]     i_first_end_x,
    input  logic signed [COORD_BITS-1:0]     i_first_end_y,
    input  logic signed [COORD_BITS-1:0]     i_first_end_z,
    input  logic signed [COORD_BITS-1:0]     i_second_start_x,
    input  logic signed [COORD_BITS-1:0]     i_second_start_y,
    input  logic signed [COORD_BITS-1:0]     i_second_start_z,
    input  logic signed [COORD_BITS-1:0]     i_second_end_x,
    input  logic signed [COORD_BITS-1:0]     i_second_end_y,
    input  logic signed [COORD_BITS-1:0]     i_second_end_z,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [ssd_pkg::OUT_W-1:0]        o_distance_squared
);

    import ssd_pkg::*;

    localparam int QB   = QUOTIENT_FRACTION_BITS;
    localparam int DW   = COORD_BITS + 1;     // coordinate differences
    localparam int PW   = 2 * DW;             // dot product terms
    localparam int TW   = PW + 2;             // dot products
    localparam int MW2  = 2 * TW;             // products of dot products
    localparam int WW   = MW2 + 1;            // determinant and numerators
    localparam int SCW  = QB + 2;             // signed line parameter
    localparam int FPW  = SCW + DW;           // parameter times direction
    localparam int PPW  = QB + DW + 3;        // closest offset component
    localparam int SQW  = 2 * PPW;
    localparam int SUMW = SQW + 2;
    localparam int SHW  = SUMW - 2 * QB;
    localparam int LAT  = QB + 15;

    // ------------------------------------------------------------------
    // pipeline control
    logic           en;
    logic [LAT-1:0] r_vld;
    logic [TOL_W-1:0] r_tol;

    assign en      = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: direction and offset vectors
    logic signed [COORD_BITS-1:0] p0 [3], p1 [3], q0 [3], q1 [3];
    logic signed [DW-1:0] r_u [3], r_v [3], r_w [3];

    assign p0[0] = i_first_start_x;
    assign p0[1] = i_first_start_y;
    assign p0[2] = i_first_start_z;
    assign p1[0] = i_first_end_x;
    assign p1[1] = i_first_end_y;
    assign p1[2] = i_first_end_z;
    assign q0[0] = i_second_start_x;
    assign q0[1] = i_second_start_y;
    assign q0[2] = i_second_start_z;
    assign q1[0] = i_second_end_x;
    assign q1[1] = i_second_end_y;
    assign q1[2] = i_second_end_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= DW'(p1[i]) - DW'(p0[i]);
                r_v[i] <= DW'(q1[i]) - DW'(q0[i]);
                r_w[i] <= DW'(p0[i]) - DW'(q0[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: dot product terms
    logic signed [PW-1:0] r_pa [3], r_pb [3], r_pc [3], r_pd [3], r_pe [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= PW'(r_u[i]) * PW'(r_u[i]);
                r_pb[i] <= PW'(r_u[i]) * PW'(r_v[i]);
                r_pc[i] <= PW'(r_v[i]) * PW'(r_v[i]);
                r_pd[i] <= PW'(r_u[i]) * PW'(r_w[i]);
                r_pe[i] <= PW'(r_v[i]) * PW'(r_w[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: dot products a through e
    logic signed [TW-1:0] r_a, r_b, r_c, r_d, r_e;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= TW'(r_pa[0]) + TW'(r_pa[1]) + TW'(r_pa[2]);
            r_b <= TW'(r_pb[0]) + TW'(r_pb[1]) + TW'(r_pb[2]);
            r_c <= TW'(r_pc[0]) + TW'(r_pc[1]) + TW'(r_pc[2]);
            r_d <= TW'(r_pd[0]) + TW'(r_pd[1]) + TW'(r_pd[2]);
            r_e <= TW'(r_pe[0]) + TW'(r_pe[1]) + TW'(r_pe[2]);
        end
    end

    // ------------------------------------------------------------------
    // stages 4-5: products of dot products
    logic signed [MW2-1:0] m_ac, m_bb, m_be, m_cd, m_ae, m_bd;

    ssd_mul #(.AW(TW)) u_mul_ac (.i_clk, .i_en(en), .i_a(r_a), .i_b(r_c), .o_p(m_ac));
    ssd_mul #(.AW(TW)) u_mul_bb (.i_clk, .i_en(en), .i_a(r_b), .i_b(r_b), .o_p(m_bb));
    ssd_mul #(.AW(TW)) u_mul_be (.i_clk, .i_en(en), .i_a(r_b), .i_b(r_e), .o_p(m_be));
    ssd_mul #(.AW(TW)) u_mul_cd (.i_clk, .i_en(en), .i_a(r_c), .i_b(r_d), .o_p(m_cd));
    ssd_mul #(.AW(TW)) u_mul_ae (.i_clk, .i_en(en), .i_a(r_a), .i_b(r_e), .o_p(m_ae));
    ssd_mul #(.AW(TW)) u_mul_bd (.i_clk, .i_en(en), .i_a(r_b), .i_b(r_d), .o_p(m_bd));

    // carry the dot products to the clamp stage
    logic [5*TW-1:0]      dots_q;
    logic signed [TW-1:0] dl_a, dl_b, dl_c, dl_d, dl_e;

    ssd_delay #(.W(5*TW), .N(3)) u_dly_dots (
        .i_clk,
        .i_en (en),
        .i_d  ({r_a, r_b, r_c, r_d, r_e}),
        .o_q  (dots_q)
    );

    assign dl_a = dots_q[5*TW-1:4*TW];
    assign dl_b = dots_q[4*TW-1:3*TW];
    assign dl_c = dots_q[3*TW-1:2*TW];
    assign dl_d = dots_q[2*TW-1:TW];
    assign dl_e = dots_q[TW-1:0];

    // ------------------------------------------------------------------
    // stage 6: determinant and unclamped numerators
    logic signed [WW-1:0] r_det, r_sn0, r_tn0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_det <= WW'(m_ac) - WW'(m_bb);
            r_sn0 <= WW'(m_be) - WW'(m_cd);
            r_tn0 <= WW'(m_ae) - WW'(m_bd);
        end
    end

    // ------------------------------------------------------------------
    // stage 7: parallel fallback and clamp of s
    logic signed [WW-1:0] abs_det, ext_b, ext_c, ext_e;
    logic                 par;
    logic signed [WW-1:0] n7_sn, n7_sd, n7_tn, n7_td;
    logic signed [TW:0]   n7_nd, n7_nb;
    logic signed [WW-1:0] r7_sn, r7_sd, r7_tn, r7_td;
    logic signed [TW:0]   r7_nd, r7_nb, r7_a;
    logic                 r7_nd_gt, r7_nb_gt;

    always_comb begin
        abs_det = r_det[WW-1] ? -r_det : r_det;
        par     = unsigned'(abs_det) <= WW'(r_tol);
        ext_b   = WW'(dl_b);
        ext_c   = WW'(dl_c);
        ext_e   = WW'(dl_e);
        if (par) begin
            n7_sn = '0;
            n7_sd = WW'(1);
            n7_tn = ext_e;
            n7_td = ext_c;
        end else begin
            n7_sd = r_det;
            n7_td = r_det;
            n7_sn = r_sn0;
            n7_tn = r_tn0;
            if (r_sn0[WW-1]) begin
                n7_sn = '0;
                n7_tn = ext_e;
                n7_td = ext_c;
            end else if (r_sn0 > r_det) begin
                n7_sn = r_det;
                n7_tn = ext_e + ext_b;
                n7_td = ext_c;
            end
        end
        n7_nd = -((TW+1)'(dl_d));
        n7_nb = n7_nd + (TW+1)'(dl_b);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_sn    <= n7_sn;
            r7_sd    <= n7_sd;
            r7_tn    <= n7_tn;
            r7_td    <= n7_td;
            r7_nd    <= n7_nd;
            r7_nb    <= n7_nb;
            r7_a     <= (TW+1)'(dl_a);
            r7_nd_gt <= n7_nd > (TW+1)'(dl_a);
            r7_nb_gt <= n7_nb > (TW+1)'(dl_a);
        end
    end

    // ------------------------------------------------------------------
    // stage 8: clamp of t and recompute of s
    logic signed [WW-1:0] n8_sn, n8_sd, n8_tn, n8_td;
    logic signed [WW-1:0] r8_sn, r8_sd, r8_tn, r8_td;

    always_comb begin
        n8_sn = r7_sn;
        n8_sd = r7_sd;
        n8_tn = r7_tn;
        n8_td = r7_td;
        if (r7_tn[WW-1]) begin
            n8_tn = '0;
            if (r7_nd[TW]) begin
                n8_sn = '0;
            end else if (r7_nd_gt) begin
                n8_sn = r7_sd;
            end else begin
                n8_sn = WW'(r7_nd);
                n8_sd = WW'(r7_a);
            end
        end else if (r7_tn > r7_td) begin
            n8_tn = r7_td;
            if (r7_nb[TW]) begin
                n8_sn = '0;
            end else if (r7_nb_gt) begin
                n8_sn = r7_sd;
            end else begin
                n8_sn = WW'(r7_nb);
                n8_sd = WW'(r7_a);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_sn <= n8_sn;
            r8_sd <= n8_sd;
            r8_tn <= n8_tn;
            r8_td <= n8_td;
        end
    end

    // ------------------------------------------------------------------
    // stages 9 to QB+10: line parameters as fractions
    logic [QB:0] q_s, q_t;

    ssd_div #(.NW(WW), .QB(QB)) u_div_s (
        .i_clk, .i_en(en), .i_num(r8_sn), .i_den(r8_sd), .o_q(q_s)
    );
    ssd_div #(.NW(WW), .QB(QB)) u_div_t (
        .i_clk, .i_en(en), .i_num(r8_tn), .i_den(r8_td), .o_q(q_t)
    );

    // carry the vectors to the distance stages
    logic [9*DW-1:0]      uvw_d, uvw_q;
    logic signed [DW-1:0] dl_u [3], dl_v [3], dl_w [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            uvw_d[i*DW +: DW]       = r_u[i];
            uvw_d[(i+3)*DW +: DW]   = r_v[i];
            uvw_d[(i+6)*DW +: DW]   = r_w[i];
            dl_u[i] = uvw_q[i*DW +: DW];
            dl_v[i] = uvw_q[(i+3)*DW +: DW];
            dl_w[i] = uvw_q[(i+6)*DW +: DW];
        end
    end

    ssd_delay #(.W(9*DW), .N(QB+9)) u_dly_uvw (
        .i_clk,
        .i_en (en),
        .i_d  (uvw_d),
        .o_q  (uvw_q)
    );

    // ------------------------------------------------------------------
    // stage QB+11: parameter times direction
    logic signed [FPW-1:0] r_fu [3], r_fv [3];
    logic signed [DW-1:0]  r_fw [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_fu[i] <= FPW'(signed'({1'b0, q_s})) * FPW'(dl_u[i]);
                r_fv[i] <= FPW'(signed'({1'b0, q_t})) * FPW'(dl_v[i]);
                r_fw[i] <= dl_w[i];
            end
        end
    end

    // stage QB+12: closest offset w + sc*u - tc*v
    logic signed [PPW-1:0] r_p [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= (PPW'(r_fw[i]) <<< QB) + PPW'(r_fu[i]) - PPW'(r_fv[i]);
            end
        end
    end

    // stages QB+13 and QB+14: squares
    logic signed [SQW-1:0] sq [3];

    for (genvar g = 0; g < 3; g++) begin : g_sq
        ssd_mul #(.AW(PPW)) u_mul_sq (
            .i_clk, .i_en(en), .i_a(r_p[g]), .i_b(r_p[g]), .o_p(sq[g])
        );
    end

    // stage QB+15: sum, drop fraction bits, saturate to OUT_W bits if wider
    logic [SUMW-1:0]  sum;
    logic [SHW-1:0]   sum_sh;
    logic [OUT_W-1:0] n_out;
    logic [OUT_W-1:0] r_out;

    assign sum    = SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);
    assign sum_sh = sum[SUMW-1:2*QB];

    if (SHW > OUT_W) begin : g_sat
        assign n_out = (|sum_sh[SHW-1:OUT_W]) ? '1 : sum_sh[OUT_W-1:0];
    end else begin : g_nosat
        assign n_out = OUT_W'(sum_sh);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_distance_squared = r_out;

endmodule

// File: hw/rtl/ssd_checker.sv
// Port-level checks on the segment distance block's output handshake.
// Depends on ssd_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module ssd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [ssd_pkg::OUT_W-1:0] o_distance_squared
);

    // a stalled result holds until its transfer
    `SSD_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_distance_squared))

    // input side stalls only behind a blocked result
    `SSD_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> o_valid && i_stall)

    // reset drains the pipeline
    `SSD_ASSERT_NORST(a_reset_clear, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind segment_segment_distance_sq ssd_checker u_ssd_checker (.*);
